// File: design/lottery_process_scheduler_defines.svh
// Assertion helpers used by the scheduler's datapath.
`ifndef LOTTERY_PROCESS_SCHEDULER_DEFINES_SVH
`define LOTTERY_PROCESS_SCHEDULER_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define LPS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lottery scheduler check failed");

// Consequent checked in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lottery scheduler check failed");

`endif

// File: design/lps_pkg.sv
package lps_pkg;

  localparam int unsigned MAX_PROCS_DEF = 16;
  localparam int unsigned ID_BITS_DEF   = 8;

  localparam int unsigned RAND_BITS     = 31;
  localparam int unsigned RUN_BITS      = 16;
  localparam int unsigned PROC_ID_BITS  = 8;
  localparam int unsigned WAIT_CNT_BITS = 5;

  localparam logic KIND_ADMIT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [1:0] ADM_OK   = 2'd0;
  localparam logic [1:0] ADM_FULL = 2'd1;
  localparam logic [1:0] ADM_ZERO = 2'd2;

  localparam logic [1:0] PRIO_LOW    = 2'd0;
  localparam logic [1:0] PRIO_NORMAL = 2'd1;

  localparam logic [1:0] TK_LOW    = 2'd1;
  localparam logic [1:0] TK_NORMAL = 2'd2;
  localparam logic [1:0] TK_HIGH   = 2'd3;

  typedef struct packed {
    logic                    req_type;
    logic [PROC_ID_BITS-1:0] proc_id;
    logic [RUN_BITS-1:0]     run_length;
    logic [1:0]              prio_level;
    logic [RAND_BITS-1:0]    random_value;
  } lps_in_t;

  typedef struct packed {
    logic                     result_kind;
    logic [1:0]               admit_status;
    logic                     running_valid;
    logic [PROC_ID_BITS-1:0]  running_id;
    logic                     finished;
    logic [WAIT_CNT_BITS-1:0] waiting_count;
  } lps_out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_walk;
    logic chk;
    logic rd_shift;
    logic wr_shift;
    logic cnt_dec;
    logic out_load;
  } lps_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic div_last;
    logic hit;
    logic exhausted;
    logic shift_more;
    logic shift_cont;
    logic out_free;
  } lps_sts_t;

  // Unused priority code saturates to high.
  function automatic logic [1:0] tickets_for(input logic [1:0] prio);
    logic [1:0] tk;
    unique case (prio)
      PRIO_LOW:    tk = TK_LOW;
      PRIO_NORMAL: tk = TK_NORMAL;
      default:     tk = TK_HIGH;
    endcase
    return tk;
  endfunction

endpackage

// File: design/lps_ctrl.sv
module lps_ctrl import lps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lps_sts_t sts_i,
  output lps_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_SHRD = 3'd4;
  localparam logic [2:0] S_SHWR = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.tick_go ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_walk = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        if (!sts_i.hit) begin
          state_d = S_RD;
        end else if (!sts_i.exhausted) begin
          state_d = S_DONE;
        end else if (sts_i.shift_more) begin
          state_d = S_SHRD;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_SHRD: begin
        cmd_o.rd_shift = 1'b1;
        state_d        = S_SHWR;
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        if (sts_i.shift_cont) begin
          state_d = S_SHRD;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/lps_dpath.sv
`include "lottery_process_scheduler_defines.svh"

module lps_dpath import lps_pkg::*; #(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lps_in_t  in_i,
  input  lps_cmd_t cmd_i,
  output lps_sts_t sts_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output lps_out_t out_o
);

  localparam int unsigned IW  = $clog2(MAX_PROCS);
  localparam int unsigned CW  = $clog2(MAX_PROCS + 1);
  localparam int unsigned TW  = $clog2(3 * MAX_PROCS + 1);
  localparam int unsigned EW  = ID_BITS + RUN_BITS + 2;
  localparam int unsigned BCW = $clog2(RAND_BITS);

  // entry table: {id, remaining, tickets}
  logic [EW-1:0] mem_q [MAX_PROCS];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic [CW-1:0]        count_q, count_d;
  logic [TW-1:0]        total_q, total_d;
  logic [IW-1:0]        idx_q;
  logic [TW-1:0]        upper_q;
  logic [TW-1:0]        rem_q;
  logic [RAND_BITS-1:0] dvd_q;
  logic [BCW-1:0]       bit_cnt_q;

  logic                    res_kind_q;
  logic [1:0]              res_status_q;
  logic                    res_run_q;
  logic [PROC_ID_BITS-1:0] res_id_q;
  logic                    res_done_q;
  lps_out_t                out_q;
  logic                    out_valid_q, out_valid_d;

  logic [ID_BITS-1:0]  rd_id;
  logic [RUN_BITS-1:0] rd_rem, rem_dec;
  logic [1:0]          rd_tk, tk_in;
  logic [TW-1:0]       upper_nx;
  logic [TW:0]         rem_sh, rem_nx;
  logic                full, zero_len, admit_ok, hit, exhausted;
  logic [1:0]          adm_status;
  logic [CW-1:0]       idx_p1;
  logic [CW:0]         idx_p2;

  logic [ID_BITS+PROC_ID_BITS-1:0] id_in_ext, id_out_ext;
  logic [ID_BITS-1:0]              id_in;
  logic [CW+WAIT_CNT_BITS-1:0]     wc_ext;

  assign rd_id  = rd_q[EW-1 -: ID_BITS];
  assign rd_rem = rd_q[RUN_BITS+1:2];
  assign rd_tk  = rd_q[1:0];

  // keep the low id bits that the table stores
  assign id_in_ext  = {{ID_BITS{1'b0}}, in_i.proc_id};
  assign id_in      = id_in_ext[ID_BITS-1:0];
  assign id_out_ext = {{PROC_ID_BITS{1'b0}}, rd_id};
  assign tk_in      = tickets_for(in_i.prio_level);

  assign full       = (count_q == CW'(MAX_PROCS));
  assign zero_len   = (in_i.run_length == '0);
  assign admit_ok   = cmd_i.load && (in_i.req_type == KIND_ADMIT) && !full && !zero_len;
  assign adm_status = full ? ADM_FULL : (zero_len ? ADM_ZERO : ADM_OK);

  // restoring remainder step, one dividend bit per cycle
  assign rem_sh = {rem_q, dvd_q[RAND_BITS-1]};
  assign rem_nx = (rem_sh >= {1'b0, total_q}) ? rem_sh - {1'b0, total_q} : rem_sh;

  assign upper_nx  = upper_q + TW'(rd_tk);
  assign hit       = (rem_q < upper_nx);
  assign rem_dec   = rd_rem - RUN_BITS'(1);
  assign exhausted = (rem_dec == '0);
  assign idx_p1    = CW'(idx_q) + CW'(1);
  assign idx_p2    = (CW+1)'(idx_q) + (CW+1)'(2);

  assign sts_o.tick_go    = (in_i.req_type == KIND_TICK) && (total_q != '0);
  assign sts_o.div_last   = (bit_cnt_q == '0);
  assign sts_o.hit        = hit;
  assign sts_o.exhausted  = exhausted;
  assign sts_o.shift_more = (idx_p1 < count_q);
  assign sts_o.shift_cont = (idx_p2 < (CW+1)'(count_q));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign raddr = cmd_i.rd_shift ? idx_q + IW'(1) : idx_q;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rd_q;
    if (admit_ok) begin
      we    = 1'b1;
      waddr = count_q[IW-1:0];
      wdata = {id_in, in_i.run_length, tk_in};
    end else if (cmd_i.chk && hit && !exhausted) begin
      we    = 1'b1;
      wdata = {rd_id, rem_dec, rd_tk};
    end else if (cmd_i.wr_shift) begin
      // move the next entry down one slot
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_walk || cmd_i.rd_shift) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (admit_ok) begin
      count_d = count_q + CW'(1);
      total_d = total_q + TW'(tk_in);
    end
    if (cmd_i.chk && hit && exhausted) begin
      total_d = total_q - TW'(rd_tk);
    end
    if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q        <= '0;
      upper_q      <= '0;
      rem_q        <= '0;
      dvd_q        <= in_i.random_value;
      bit_cnt_q    <= BCW'(RAND_BITS - 1);
      res_kind_q   <= in_i.req_type;
      res_status_q <= (in_i.req_type == KIND_ADMIT) ? adm_status : ADM_OK;
      res_run_q    <= 1'b0;
      res_id_q     <= '0;
      res_done_q   <= 1'b0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= rem_nx[TW-1:0];
      dvd_q     <= {dvd_q[RAND_BITS-2:0], 1'b0};
      bit_cnt_q <= bit_cnt_q - BCW'(1);
    end
    if (cmd_i.chk) begin
      if (hit) begin
        res_run_q  <= 1'b1;
        res_id_q   <= id_out_ext[PROC_ID_BITS-1:0];
        res_done_q <= exhausted;
      end else begin
        idx_q   <= idx_q + IW'(1);
        upper_q <= upper_nx;
      end
    end
    if (cmd_i.wr_shift) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  assign wc_ext = {{WAIT_CNT_BITS{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.result_kind   <= res_kind_q;
      out_q.admit_status  <= res_status_q;
      out_q.running_valid <= res_run_q;
      out_q.running_id    <= res_id_q;
      out_q.finished      <= res_done_q;
      out_q.waiting_count <= wc_ext[WAIT_CNT_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `LPS_ASSERT_ALWAYS(a_count_max, count_q <= CW'(MAX_PROCS))
  `LPS_ASSERT_ALWAYS(a_total_empty, (total_q == '0) == (count_q == '0))
  `LPS_ASSERT_ALWAYS(a_draw_range, !cmd_i.chk || (rem_q < total_q))
  `LPS_ASSERT_NEXT(a_admit_grow, admit_ok, count_q == $past(count_q) + CW'(1))

endmodule

// File: design/lottery_process_scheduler.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_i  (lps_in_t)
// out       output     out_valid_o / out_ready_i  out_o (lps_out_t)
//
// An admit writes the table in the cycle it is accepted, then posts its result.
// A tick runs a one-bit-per-cycle remainder unit, then a table walk up to the
// winner's table position and, when the winner finishes, a compaction of the
// entries behind it through the single read port of the entry memory.
// A tick with no processes skips the draw. Reset empties the table at once.
// A stalled output holds the finished result while the next item is taken.
module lottery_process_scheduler import lps_pkg::*; #(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lps_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lps_out_t out_o
);

  lps_cmd_t cmd;
  lps_sts_t sts;

  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lps_dpath #(
    .MAX_PROCS (MAX_PROCS),
    .ID_BITS   (ID_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule
